@@ rtl/lpr_pkg.sv @@
// Shared types and constants for the Legendre polynomial recurrence block.
// Holds the controller state type, the command and status structs and the fixed-point helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package lpr_pkg;

  localparam int X_W       = 32;
  localparam int CNT_W     = 7;
  localparam int DEG_W     = 6;
  localparam int FRAC_BITS = 30;
  localparam int PROD_W    = 64;

  localparam logic [CNT_W-1:0] ORDER_RESET = 7'd16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ERR,
    ST_EMIT,
    ST_SETX,
    ST_MUL_AB,
    ST_ROUND_AB,
    ST_MUL_C,
    ST_CALC
  } lpr_state_t;

  typedef struct packed {
    logic load;
    logic set_x;
    logic mul_ab;
    logic round_ab;
    logic mul_c;
    logic calc;
    logic emit;
    logic emit_err;
  } lpr_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic range_bad;
    logic out_free;
    logic last_deg;
    logic deg_zero;
  } lpr_status_t;

  // Round to nearest at the binary point, ties toward plus infinity.
  // Adding one half and shifting arithmetically gives the floor in both signs.
  function automatic logic signed [PROD_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    r = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
    return r >>> FRAC_BITS;
  endfunction

endpackage

@@ rtl/legendre_polynomial_recurrence_top.sv @@
// Legendre polynomial recurrence generator.
// Each sample x (signed Q1.30) on the input channel (in_valid, in_stall) yields the items
// P0(x) .. P(L-1)(x) in degree order on the output channel (out_valid, out_stall),
// where L is the order count written on the configuration channel (cfg_valid,
// cfg_ready, cfg_data; reset value 16, values above MAX_ORDER act as MAX_ORDER).
// An order count of zero gives no items; else a sample with |x| above one gives a single
// item with range_error and last set and no values. The last item of a sample has last set.
// Steps: the sample is checked in the cycle after acceptance, then P0 is emitted, then
// P1 (x itself), and each higher degree runs two multiply steps, rounding and the
// saturating subtract before its emit, all through one shared recurrence loop.
// A new sample is accepted only once the previous one has handed its last item to the
// output register. When the receiver stalls, the output register holds its item and
// the recurrence waits before the next degree. Reset returns the block to idle,
// empties the output register and sets the order count to 16.
// Depends on lpr_pkg, lpr_ctrl and lpr_datapath.
`timescale 1ns / 1ps

module legendre_polynomial_recurrence_top
  import lpr_pkg::*;
#(
  parameter int MAX_ORDER = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [X_W-1:0] x,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DEG_W-1:0]      degree,
  output logic signed [X_W-1:0] value,
  output logic                  range_error,
  output logic                  last
);

  lpr_cmd_t    cmd;
  lpr_status_t status;

  assign cfg_ready = 1'b1;

  lpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lpr_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .x           (x),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .degree      (degree),
    .value       (value),
    .range_error (range_error),
    .last        (last),
    .cmd         (cmd),
    .status      (status)
  );

`ifndef SYNTHESIS
  // An out-of-range item is always the only item of its sample.
  a_err_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> last && (degree == '0) && (value == '0))
    else $error("range error item is not a lone degree-zero item");

  // Saturation keeps every value within plus or minus one.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (value <= (X_W'(1) <<< FRAC_BITS)) && (value >= -(X_W'(1) <<< FRAC_BITS)))
    else $error("output value outside plus or minus one");

  // Reset leaves the output register empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output item present right after reset");
`endif

endmodule

@@ rtl/lpr_ctrl.sv @@
// Controller state machine for the Legendre polynomial recurrence block.
// Sequences the datapath one degree at a time; uses lpr_pkg.
`timescale 1ns / 1ps

module lpr_ctrl
  import lpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  lpr_status_t status,
  output lpr_cmd_t    cmd
);

  lpr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (status.count_zero) state_next = ST_IDLE;
        else if (status.range_bad) state_next = ST_ERR;
        else state_next = ST_EMIT;
      end
      ST_ERR: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          priority if (status.last_deg) state_next = ST_IDLE;
          else if (status.deg_zero) state_next = ST_SETX;
          else state_next = ST_MUL_AB;
        end
      end
      ST_SETX:     state_next = ST_EMIT;
      ST_MUL_AB:   state_next = ST_ROUND_AB;
      ST_ROUND_AB: state_next = ST_MUL_C;
      ST_MUL_C:    state_next = ST_CALC;
      ST_CALC:     state_next = ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:     cmd.load     = in_valid;
      ST_CHECK:    cmd          = '0;
      ST_ERR:      cmd.emit_err = status.out_free;
      ST_EMIT:     cmd.emit     = status.out_free;
      ST_SETX:     cmd.set_x    = 1'b1;
      ST_MUL_AB:   cmd.mul_ab   = 1'b1;
      ST_ROUND_AB: cmd.round_ab = 1'b1;
      ST_MUL_C:    cmd.mul_c    = 1'b1;
      ST_CALC:     cmd.calc     = 1'b1;
      default:     cmd          = '0;
    endcase
  end

endmodule

@@ rtl/lpr_datapath.sv @@
// Datapath of the Legendre polynomial recurrence block: order register, coefficient
// table, multipliers, recurrence registers and the output register. Uses lpr_pkg.
`timescale 1ns / 1ps

module lpr_datapath
  import lpr_pkg::*;
#(
  parameter int MAX_ORDER = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  input  logic [CNT_W-1:0]        cfg_data,
  input  logic signed [X_W-1:0]   x,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [DEG_W-1:0]        degree,
  output logic signed [X_W-1:0]   value,
  output logic                    range_error,
  output logic                    last,
  input  lpr_cmd_t                cmd,
  output lpr_status_t             status
);

  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int ROM_D = 1 << IDX_W;
  localparam int AX_W  = 34;
  localparam int PB_W  = 33;
  localparam int DIF_W = 35;

  localparam logic signed [X_W-1:0]   ONE_X  = X_W'(1) <<< FRAC_BITS;
  localparam logic signed [DIF_W-1:0] SAT_HI = DIF_W'(1) <<< FRAC_BITS;
  localparam logic signed [DIF_W-1:0] SAT_LO = -SAT_HI;
  localparam logic [CNT_W-1:0]        MAX_CNT = CNT_W'(MAX_ORDER);

  // Q2.30 recurrence coefficients a_n = (2n-1)/n and b_n = (n-1)/n, rounded half up.
  // Entries for degrees below two are never used.
  logic [X_W-1:0] rom_a [ROM_D];
  logic [X_W-1:0] rom_b [ROM_D];

  for (genvar g = 0; g < ROM_D; g++) begin : g_rom
    localparam longint unsigned Den    = (g < 2) ? 2 : g;
    localparam longint unsigned CoefA  = (((2 * Den - 1) << FRAC_BITS) + Den / 2) / Den;
    localparam longint unsigned CoefB  = (((Den - 1) << FRAC_BITS) + Den / 2) / Den;
    assign rom_a[g] = X_W'(CoefA);
    assign rom_b[g] = X_W'(CoefB);
  end

  logic [CNT_W-1:0]         order_count;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         deg;
  logic signed [X_W-1:0]    x_work;
  logic signed [X_W-1:0]    pn;
  logic signed [X_W-1:0]    p1;
  logic signed [X_W-1:0]    p2;
  logic [X_W-1:0]           coef_a;
  logic [X_W-1:0]           coef_b;
  logic signed [PROD_W-1:0] prod_a;
  logic signed [PROD_W-1:0] prod_b;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [AX_W-1:0]   ax;
  logic signed [PB_W-1:0]   pb;

  logic [CNT_W-1:0]         count_sat;
  logic [CNT_W-1:0]         deg_inc;
  logic signed [PROD_W-1:0] rnd_a;
  logic signed [PROD_W-1:0] rnd_b;
  logic signed [PROD_W-1:0] rnd_c;
  logic signed [AX_W-1:0]   rc;
  logic signed [DIF_W-1:0]  diff;
  logic signed [X_W-1:0]    sat_val;

  assign count_sat = (order_count > MAX_CNT) ? MAX_CNT : order_count;
  assign deg_inc   = deg + CNT_W'(1);

  assign rnd_a = round_q(prod_a);
  assign rnd_b = round_q(prod_b);
  assign rnd_c = round_q(prod_c);
  assign rc    = rnd_c[AX_W-1:0];
  assign diff  = {rc[AX_W-1], rc} - {{(DIF_W-PB_W){pb[PB_W-1]}}, pb};

  always_comb begin
    priority if (diff > SAT_HI) sat_val = SAT_HI[X_W-1:0];
    else if (diff < SAT_LO) sat_val = SAT_LO[X_W-1:0];
    else sat_val = diff[X_W-1:0];
  end

  assign status.count_zero = (count == '0);
  assign status.range_bad  = (x_work > ONE_X) || (x_work < -ONE_X);
  assign status.out_free   = !out_valid || !out_stall;
  assign status.last_deg   = (deg_inc == count);
  assign status.deg_zero   = (deg == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      order_count <= ORDER_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) order_count <= cfg_data;
      if (cmd.emit || cmd.emit_err) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_work <= x;
      count  <= count_sat;
      deg    <= '0;
      pn     <= ONE_X;
      p1     <= '0;
      p2     <= '0;
    end
    if (cmd.set_x) pn <= x_work;
    if (cmd.mul_ab) begin
      prod_a <= PROD_W'($signed({1'b0, coef_a}) * x_work);
      prod_b <= PROD_W'($signed({1'b0, coef_b}) * p2);
    end
    if (cmd.round_ab) begin
      ax <= rnd_a[AX_W-1:0];
      pb <= rnd_b[PB_W-1:0];
    end
    if (cmd.mul_c) prod_c <= PROD_W'(ax * p1);
    if (cmd.calc) pn <= sat_val;
    if (cmd.emit) begin
      degree      <= deg[DEG_W-1:0];
      value       <= pn;
      range_error <= 1'b0;
      last        <= status.last_deg;
      p2          <= p1;
      p1          <= pn;
      deg         <= deg_inc;
      // The coefficients for the next degree are fetched as this one leaves.
      coef_a      <= rom_a[deg_inc[IDX_W-1:0]];
      coef_b      <= rom_b[deg_inc[IDX_W-1:0]];
    end
    if (cmd.emit_err) begin
      degree      <= '0;
      value       <= '0;
      range_error <= 1'b1;
      last        <= 1'b1;
    end
  end

endmodule
